### rtl/chb_pkg.sv
package chb_pkg;

   // size field width default
   localparam int SIZE_BITS_DEFAULT = 32;

   // reset value of the body length limit
   localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

   // input selector codes
   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_END  = 2'd1;
   localparam logic [1:0] FUNC_NEW  = 2'd2;

   // result kind codes
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_BAD_SIZE  = 2'd0;
   localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
   localparam logic [1:0] ERR_EARLY_END = 2'd2;

   // line characters
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // bytes dropped after each chunk and after the zero chunk
   localparam logic [1:0] TRAILER_SKIP = 2'd2;

   // one result item
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] body_byte;
      logic [1:0] error_code;
      logic       last;
   } chb_result_type;

   // hex digit detect
   function automatic logic is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // hex digit value, only meaningful when is_hex
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "a" && c <= "f") begin
         v = c - 8'h57;
      end else begin
         v = c - 8'h37;
      end
      return v[3:0];
   endfunction

   // space, tab, lf, vt, ff, cr
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

### rtl/chb_parse.sv
module chb_parse
   import chb_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  logic [1:0]     item_func,
   input  logic [7:0]     item_byte,
   input  logic           csr_wr_en,
   input  logic [31:0]    csr_wr_data,
   output logic           res_valid,
   output chb_result_type res
);

   localparam int SUM_W = ((SIZE_BITS > 33) ? SIZE_BITS : 33) + 1;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_DIGITS,
      PH_REST,
      PH_DATA,
      PH_SKIP,
      PH_FINAL,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 digits_ff, digits_in;
   logic                 cr_ff, cr_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic [1:0]           skip_ff, skip_in;
   logic [32:0]          total_ff, total_in;
   logic [31:0]          max_body_ff;
   logic [SUM_W-1:0]     new_total;
   logic                 too_large;

   // running total plus the size just read, against the limit
   // a limit lowered below the running total leaves the room unbounded
   assign new_total = SUM_W'(size_ff) + SUM_W'(total_ff);
   assign too_large = (total_ff <= {1'b0, max_body_ff}) &&
                      (new_total > SUM_W'(max_body_ff));

   // next state and result
   always_comb begin
      phase_type cur;
      phase_in  = phase_ff;
      size_in   = size_ff;
      digits_in = digits_ff;
      cr_in     = cr_ff;
      left_in   = left_ff;
      skip_in   = skip_ff;
      total_in  = total_ff;
      res_valid = 1'b0;
      res       = '0;
      cur       = phase_ff;
      if (item_valid) begin
         case (item_func)
            FUNC_NEW: begin
               phase_in  = PH_LEAD;
               size_in   = '0;
               digits_in = 1'b0;
               cr_in     = 1'b0;
               left_in   = '0;
               skip_in   = '0;
               total_in  = '0;
            end
            FUNC_END: begin
               if (phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERR;
                  res.error_code = ERR_EARLY_END;
                  res.last       = 1'b1;
                  phase_in       = PH_ERROR;
               end
            end
            FUNC_BYTE: begin
               case (phase_ff)
                  PH_LEAD, PH_DIGITS, PH_REST: begin
                     if (cr_ff && item_byte == CHAR_LF) begin
                        // crlf closes the size line
                        cr_in = 1'b0;
                        if (!digits_ff) begin
                           res_valid      = 1'b1;
                           res.kind       = KIND_ERR;
                           res.error_code = ERR_BAD_SIZE;
                           res.last       = 1'b1;
                           phase_in       = PH_ERROR;
                        end else if (size_ff == '0) begin
                           phase_in = PH_FINAL;
                           skip_in  = TRAILER_SKIP;
                        end else if (too_large) begin
                           res_valid      = 1'b1;
                           res.kind       = KIND_ERR;
                           res.error_code = ERR_TOO_LARGE;
                           res.last       = 1'b1;
                           phase_in       = PH_ERROR;
                        end else begin
                           total_in = new_total[32:0];
                           left_in  = size_ff;
                           phase_in = PH_DATA;
                        end
                     end else begin
                        // lone cr: blank before digits, terminator after
                        if (cr_ff) begin
                           cr_in = 1'b0;
                           cur   = (phase_ff == PH_LEAD) ? PH_LEAD : PH_REST;
                        end
                        if (item_byte == CHAR_CR) begin
                           cr_in    = 1'b1;
                           phase_in = cur;
                        end else if (cur == PH_LEAD && is_blank(item_byte)) begin
                           phase_in = cur;
                        end else if ((cur == PH_LEAD || cur == PH_DIGITS) &&
                                     is_hex(item_byte)) begin
                           if (size_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                              res_valid      = 1'b1;
                              res.kind       = KIND_ERR;
                              res.error_code = ERR_BAD_SIZE;
                              res.last       = 1'b1;
                              phase_in       = PH_ERROR;
                           end else begin
                              size_in   = {size_ff[SIZE_BITS-5:0], hex_val(item_byte)};
                              digits_in = 1'b1;
                              phase_in  = PH_DIGITS;
                           end
                        end else begin
                           phase_in = PH_REST;
                        end
                     end
                  end
                  PH_DATA: begin
                     left_in = left_ff - SIZE_BITS'(1);
                     if (left_ff == SIZE_BITS'(1)) begin
                        phase_in = PH_SKIP;
                        skip_in  = TRAILER_SKIP;
                     end
                     res_valid     = 1'b1;
                     res.kind      = KIND_BYTE;
                     res.body_byte = item_byte;
                  end
                  PH_SKIP: begin
                     if (skip_ff <= 2'd1) begin
                        skip_in   = '0;
                        phase_in  = PH_LEAD;
                        size_in   = '0;
                        digits_in = 1'b0;
                        cr_in     = 1'b0;
                     end else begin
                        skip_in = skip_ff - 2'd1;
                     end
                  end
                  PH_FINAL: begin
                     if (skip_ff <= 2'd1) begin
                        skip_in  = '0;
                        res_valid = 1'b1;
                        res.kind  = KIND_DONE;
                        res.last  = 1'b1;
                        phase_in  = PH_DONE;
                     end else begin
                        skip_in = skip_ff - 2'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // state and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEAD;
         size_ff     <= '0;
         digits_ff   <= 1'b0;
         cr_ff       <= 1'b0;
         left_ff     <= '0;
         skip_ff     <= '0;
         total_ff    <= '0;
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         phase_ff  <= phase_in;
         size_ff   <= size_in;
         digits_ff <= digits_in;
         cr_ff     <= cr_in;
         left_ff   <= left_in;
         skip_ff   <= skip_in;
         total_ff  <= total_in;
         if (csr_wr_en) begin
            max_body_ff <= csr_wr_data;
         end
      end
   end

   // an error result parks the parser in the error phase
   a_err_sticks: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_ERR) |=> (phase_ff == PH_ERROR))
      else $error("error result did not enter error phase");

   // data phase always has bytes outstanding
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (left_ff != '0))
      else $error("data phase with no bytes left");

endmodule

### rtl/chb_outq.sv
module chb_outq
   import chb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  chb_result_type push_data,
   output logic           not_full,
   output logic           out_valid,
   input  logic           out_ready,
   output chb_result_type out_data
);

   logic [1:0]     count_ff, count_in;
   chb_result_type head_ff, head_in;
   chb_result_type tail_ff, tail_in;
   logic           pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign not_full  = (count_ff != 2'd2);

   // two-entry buffer, head always presented
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               tail_in  = push_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // occupancy never passes two
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer overfilled");

   // a full buffer with no pop keeps its head item
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2 && $stable(head_ff)))
      else $error("full output buffer changed without a pop");

endmodule

### rtl/http_chunked_body_decoder.sv
// Chunked transfer body decoder. Feed the bytes that follow the message headers one item
// per cycle on the req_ channel (tuser selects stream byte, end of input or start of a new
// body) and the decoded body bytes come out on the rsp_ channel, followed by one body
// complete item or one error item, both marked with tlast. Each item is decoded in the
// cycle it is accepted, so the block sustains one item per clock; results pass through a
// two-entry output buffer, so req_tready only drops when both entries are held by a stalled
// rsp_ side. Errors and completion are sticky until a start-new-body item. The user must write the body
// length limit through csr_wr_en/csr_wr_data only while the block is idle; the block itself does
// not enforce this. SIZE_BITS sets the largest chunk size the size line may carry.
module http_chunked_body_decoder
   import chb_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] body_byte, [9:8] error_code, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic           accept;
   logic           res_valid;
   chb_result_type res;
   chb_result_type out_item;

   assign accept = req_tvalid && req_tready;

   // byte parser and chunk state
   chb_parse #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item_func  (req_tuser),
      .item_byte  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .res_valid  (res_valid),
      .res        (res)
   );

   // result buffer
   chb_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res),
      .not_full (req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (out_item)
   );

   // pack result fields
   assign rsp_tdata = {6'd0, out_item.error_code, out_item.body_byte};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule
